/* design/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder: the classified
// byte word passed from front to back, result word and status codes.
// ----------------------------------------------------------------------------
package u8d_pkg;

    // Depth of the queue between front and back
    localparam int IN_DEPTH  = 4;
    localparam int IN_PTR_W  = $clog2(IN_DEPTH);
    localparam int IN_CNT_W  = $clog2(IN_DEPTH + 1);

    // Depth of the result queue
    localparam int OUT_DEPTH = 2;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    // code_point[20:11] of a surrogate (0xD800..0xDFFF)
    localparam logic [9:0]      SURROGATE_HI   = 10'h01B;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_BAD_LEAD  = 2'd3;

    // Byte kind as seen when no sequence is open
    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_BAD
    } kind_t;

    // Classified byte word
    typedef struct packed {
        kind_t      kind;
        logic       is_cont;    // 10xxxxxx
        logic       lead_bad;   // overlong or above-range lead
        logic       lead_e0;
        logic       lead_ed;
        logic       lead_f0;
        logic       lead_f4;
        logic       sec_a0_bf;  // second-byte windows
        logic       sec_le_9f;
        logic       sec_90_bf;
        logic       sec_le_8f;
        logic [7:0] data;
        logic       last;       // end of text
    } item_t;

    // Result word
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [2:0]      byte_count;
        logic [1:0]      status;
    } result_t;

endpackage

/* design/u8d_front.sv */
// ----------------------------------------------------------------------------
// u8d_front
// Accepts raw bytes, classifies each one independently of decoder state and
// queues the classified word for the back end.
// ----------------------------------------------------------------------------
module u8d_front
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output logic       full,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_take
);

    item_t                 queue_mem [IN_DEPTH];
    logic [IN_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IN_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IN_CNT_W-1:0]   count_reg, count_next;
    item_t                 cls;
    logic                  wr_en;
    logic                  rd_en;

    // Byte classification
    always_comb
    begin
        cls = '0;
        if (data_byte[7] == 1'b0)
            cls.kind = KIND_ASCII;
        else if (data_byte[7:5] == 3'b110)
            cls.kind = KIND_LEAD2;
        else if (data_byte[7:4] == 4'b1110)
            cls.kind = KIND_LEAD3;
        else if (data_byte[7:3] == 5'b11110)
            cls.kind = KIND_LEAD4;
        else
            cls.kind = KIND_BAD;
        cls.is_cont   = (data_byte[7:6] == 2'b10);
        cls.lead_bad  = ((cls.kind == KIND_LEAD2) && (data_byte < 8'hC2))
                     || ((cls.kind == KIND_LEAD4) && (data_byte > 8'hF4));
        cls.lead_e0   = (data_byte == 8'hE0);
        cls.lead_ed   = (data_byte == 8'hED);
        cls.lead_f0   = (data_byte == 8'hF0);
        cls.lead_f4   = (data_byte == 8'hF4);
        cls.sec_a0_bf = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
        cls.sec_le_9f = (data_byte <= 8'h9F);
        cls.sec_90_bf = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
        cls.sec_le_8f = (data_byte <= 8'h8F);
        cls.data      = data_byte;
        cls.last      = end_of_text;
    end

    // Queue control
    assign full       = (count_reg == IN_CNT_W'(IN_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = queue_mem[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + IN_CNT_W'(wr_en) - IN_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[wr_ptr_reg] <= cls;
    end

endmodule

/* design/u8d_back.sv */
// ----------------------------------------------------------------------------
// u8d_back
// Sequence assembler: takes classified bytes, tracks the open sequence,
// checks it and writes finished characters to a small result queue.
// ----------------------------------------------------------------------------
module u8d_back
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  item_t           item,
    output logic            item_take,
    input  logic            pop,
    output logic            empty,
    output logic [CP_W-1:0] code_point,
    output logic [2:0]      byte_count,
    output logic [1:0]      status
);

    // Sequence state
    logic [2:0]      expected_reg, expected_next;
    logic [2:0]      seen_reg, seen_next;
    logic [CP_W-1:0] accum_reg, accum_next;
    logic            lead_e0_reg, lead_e0_next;
    logic            lead_ed_reg, lead_ed_next;
    logic            lead_f0_reg, lead_f0_next;
    logic            lead_f4_reg, lead_f4_next;
    logic            bad_reg, bad_next;

    // Result queue
    result_t              res_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] res_wr_reg, res_wr_next;
    logic [OUT_PTR_W-1:0] res_rd_reg, res_rd_next;
    logic [OUT_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    logic            res_push;
    result_t         res;
    logic            res_pop;
    logic            bad_cont;
    logic [2:0]      seen_inc;
    logic [CP_W-1:0] accum_cont;

    assign item_take = item_valid && (res_cnt_reg != OUT_CNT_W'(OUT_DEPTH));
    assign empty     = (res_cnt_reg == '0);
    assign res_pop   = pop && !empty;
    assign code_point = res_mem[res_rd_reg].code_point;
    assign byte_count = res_mem[res_rd_reg].byte_count;
    assign status     = res_mem[res_rd_reg].status;

    // Continuation byte checks and payload merge
    always_comb
    begin
        seen_inc = seen_reg + 3'd1;
        bad_cont = bad_reg || !item.is_cont
                || ((seen_reg == 3'd1)
                    && ((lead_e0_reg && !item.sec_a0_bf)
                     || (lead_ed_reg && !item.sec_le_9f)
                     || (lead_f0_reg && !item.sec_90_bf)
                     || (lead_f4_reg && !item.sec_le_8f)));
        case (expected_reg - seen_inc)
            3'd0:    accum_cont = accum_reg | {15'b0, item.data[5:0]};
            3'd1:    accum_cont = accum_reg | {9'b0, item.data[5:0], 6'b0};
            default: accum_cont = accum_reg | {3'b0, item.data[5:0], 12'b0};
        endcase
    end

    // Sequence tracking
    always_comb
    begin
        expected_next = expected_reg;
        seen_next     = seen_reg;
        accum_next    = accum_reg;
        lead_e0_next  = lead_e0_reg;
        lead_ed_next  = lead_ed_reg;
        lead_f0_next  = lead_f0_reg;
        lead_f4_next  = lead_f4_reg;
        bad_next      = bad_reg;
        res_push      = 1'b0;
        res           = '0;

        if (item_take)
        begin
            if (expected_reg == 3'd0)
            begin
                // No open sequence: byte is ASCII, a lead or a bad lead
                case (item.kind)
                    KIND_ASCII:
                    begin
                        res_push = 1'b1;
                        res      = '{{13'b0, item.data}, 3'd1, ST_OK};
                    end
                    KIND_LEAD2, KIND_LEAD3, KIND_LEAD4:
                    begin
                        if (item.last)
                        begin
                            res_push = 1'b1;
                            res      = '{REPLACEMENT_CP, 3'd1, ST_TRUNCATED};
                        end
                        else
                        begin
                            seen_next    = 3'd1;
                            bad_next     = item.lead_bad;
                            lead_e0_next = item.lead_e0;
                            lead_ed_next = item.lead_ed;
                            lead_f0_next = item.lead_f0;
                            lead_f4_next = item.lead_f4;
                            if (item.kind == KIND_LEAD2)
                            begin
                                expected_next = 3'd2;
                                accum_next    = {10'b0, item.data[4:0], 6'b0};
                            end
                            else if (item.kind == KIND_LEAD3)
                            begin
                                expected_next = 3'd3;
                                accum_next    = {5'b0, item.data[3:0], 12'b0};
                            end
                            else
                            begin
                                expected_next = 3'd4;
                                accum_next    = {item.data[2:0], 18'b0};
                            end
                        end
                    end
                    default:
                    begin
                        res_push = 1'b1;
                        res      = '{'0, 3'd0, ST_BAD_LEAD};
                    end
                endcase
            end
            else if (seen_inc >= expected_reg)
            begin
                // Sequence complete
                res_push = 1'b1;
                if (bad_cont || (accum_cont[20:11] == SURROGATE_HI))
                    res = '{REPLACEMENT_CP, expected_reg, ST_MALFORMED};
                else
                    res = '{accum_cont, expected_reg, ST_OK};
                expected_next = 3'd0;
            end
            else if (item.last)
            begin
                // Cut short by end of text
                res_push      = 1'b1;
                res           = '{REPLACEMENT_CP, seen_inc, ST_TRUNCATED};
                expected_next = 3'd0;
            end
            else
            begin
                seen_next  = seen_inc;
                accum_next = accum_cont;
                bad_next   = bad_cont;
            end
        end
    end

    // Result queue pointers
    always_comb
    begin
        res_wr_next  = res_push ? res_wr_reg + 1'b1 : res_wr_reg;
        res_rd_next  = res_pop ? res_rd_reg + 1'b1 : res_rd_reg;
        res_cnt_next = res_cnt_reg + OUT_CNT_W'(res_push) - OUT_CNT_W'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            seen_reg     <= '0;
            accum_reg    <= '0;
            lead_e0_reg  <= 1'b0;
            lead_ed_reg  <= 1'b0;
            lead_f0_reg  <= 1'b0;
            lead_f4_reg  <= 1'b0;
            bad_reg      <= 1'b0;
            res_wr_reg   <= '0;
            res_rd_reg   <= '0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
            accum_reg    <= accum_next;
            lead_e0_reg  <= lead_e0_next;
            lead_ed_reg  <= lead_ed_next;
            lead_f0_reg  <= lead_f0_next;
            lead_f4_reg  <= lead_f4_next;
            bad_reg      <= bad_next;
            res_wr_reg   <= res_wr_next;
            res_rd_reg   <= res_rd_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    // Result storage, no reset
    always_ff @(posedge clk)
    begin
        if (res_push)
            res_mem[res_wr_reg] <= res;
    end

endmodule

/* design/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-in, code-point-out UTF-8 decoder with a classifying front end, a
// four-word queue and a sequence-assembling back end.
//
//   channel  | handshake          | words
//   ---------+--------------------+-------------------------------------
//   in       | push / full        | data_byte[7:0], end_of_text
//   out      | pop / empty        | code_point[20:0], byte_count[2:0],
//            |                    | status[1:0]
//
// One byte per clock sustained while the out side is popped. A byte is
// classified as it is accepted and written to the byte queue; the assembler
// takes it when the result queue has room, and a result that it causes is
// written to the result queue and so reaches the out side. Reset clears
// both queues and the open sequence. A stalled out side fills the two-word
// result queue, then the four-word byte queue, and only then raises full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      data_byte,
    input  logic            end_of_text,
    input  logic            pop,
    output logic            empty,
    output logic [CP_W-1:0] code_point,
    output logic [2:0]      byte_count,
    output logic [1:0]      status
);

    item_t item;
    logic  item_valid;
    logic  item_take;

    u8d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .full        (full),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .pop        (pop),
        .empty      (empty),
        .code_point (code_point),
        .byte_count (byte_count),
        .status     (status)
    );

endmodule
